// ===== rtl/ocp_pkg.sv =====
// ----------------------------------------------------------------------------
// ocp_pkg
// Shared types, constants and the CORDIC arctangent table of the orbit camera.
// ----------------------------------------------------------------------------
`default_nettype none

package ocp_pkg;

  // iteration count of the sine/cosine unit
  localparam int CORDIC_STEPS_DEF = 16;

  // widths
  localparam int ANG_W  = 18;  // angle into the CORDIC, 1/256 degree, signed
  localparam int Z_W    = 28;  // residual angle, 1/65536 degree, signed
  localparam int XY_W   = 34;  // CORDIC vector, Q1.30 with headroom
  localparam int DIR_W  = 33;  // direction component, Q1.30
  localparam int PROD_W = 66;  // shared multiplier product

  // angles in 1/256 degree
  localparam int LAT_LIMIT    = 22784;
  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // output saturation
  localparam int POS_MAX    = 16777215;
  localparam int POS_MIN    = -16777216;
  localparam int VIEW_LIMIT = 16384;

  // reset values of the registers and of the orbit state
  localparam logic [23:0] MIN_RADIUS_RST = 24'd78643;
  localparam logic [23:0] MAX_RADIUS_RST = 24'd524288;
  localparam logic [23:0] RADIUS_RST     = 24'd327680;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [DIR_W-1:0] dir_t;

  typedef enum logic [1:0] {
    CMD_FWD    = 2'd0,
    CMD_BACK   = 2'd1,
    CMD_ORIENT = 2'd2,
    CMD_SIDE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_MIN_RADIUS = 3'd0,
    CFG_MAX_RADIUS = 3'd1,
    CFG_FOCUS_X    = 3'd2,
    CFG_FOCUS_Y    = 3'd3,
    CFG_FOCUS_Z    = 3'd4
  } cfg_idx_e;

  // result of one sine/cosine pass
  typedef struct packed {
    logic done;
    dir_t cos_v;
    dir_t sin_v;
  } cordic_res_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  function automatic logic [21:0] atan_lut(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ocp_cordic.sv =====
// ----------------------------------------------------------------------------
// ocp_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, sine and
// cosine of an angle in 1/256 degree as Q1.30.
// ----------------------------------------------------------------------------
`default_nettype none

module ocp_cordic #(
  parameter int CORDIC_STEPS = ocp_pkg::CORDIC_STEPS_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  ocp_pkg::ang_t        angle_i,
  output ocp_pkg::cordic_res_t res_o
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam int ZPAD = ocp_pkg::Z_W - ocp_pkg::ANG_W - 8;

  logic                              busy_q, done_q;
  logic [CNT_W-1:0]                  cnt_q;
  logic signed [ocp_pkg::XY_W-1:0]   x_q, y_q;
  logic signed [ocp_pkg::Z_W-1:0]    z_q;
  logic                              flip_q;

  ocp_pkg::ang_t                     a_wrap, a_red;
  logic                              flip_d;
  logic signed [ocp_pkg::Z_W-1:0]    z_init, atan_v;
  logic signed [ocp_pkg::XY_W-1:0]   dx, dy;
  logic [4:0]                        idx;
  logic                              last;

  // fold the angle into -90..90 degrees, flip the result for the far half
  always_comb begin
    a_wrap = (angle_i >= ocp_pkg::ang_t'(ocp_pkg::HALF_TURN)) ?
             angle_i - ocp_pkg::ang_t'(ocp_pkg::FULL_TURN) : angle_i;
    a_red  = a_wrap;
    flip_d = 1'b0;
    if (a_wrap > ocp_pkg::ang_t'(ocp_pkg::QUARTER_TURN)) begin
      a_red  = a_wrap - ocp_pkg::ang_t'(ocp_pkg::HALF_TURN);
      flip_d = 1'b1;
    end else if (a_wrap < -ocp_pkg::ang_t'(ocp_pkg::QUARTER_TURN)) begin
      a_red  = a_wrap + ocp_pkg::ang_t'(ocp_pkg::HALF_TURN);
      flip_d = 1'b1;
    end
    z_init = {{ZPAD{a_red[ocp_pkg::ANG_W-1]}}, a_red, 8'd0};
  end

  assign idx    = 5'(cnt_q);
  assign atan_v = ocp_pkg::Z_W'({1'b0, ocp_pkg::atan_lut(idx)});
  assign dx     = y_q >>> cnt_q;
  assign dy     = x_q >>> cnt_q;
  assign last   = (cnt_q == LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= ocp_pkg::CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= z_init;
      flip_q <= flip_d;
    end else if (busy_q) begin
      if (!z_q[ocp_pkg::Z_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_v;
      end
    end
  end

  assign res_o.done  = done_q;
  assign res_o.cos_v = ocp_pkg::DIR_W'(flip_q ? -x_q : x_q);
  assign res_o.sin_v = ocp_pkg::DIR_W'(flip_q ? -y_q : y_q);

endmodule

`default_nettype wire

// ===== rtl/ocp_mul.sv =====
// ----------------------------------------------------------------------------
// ocp_mul
// Shared signed multiplier with a registered product; holds while disabled.
// ----------------------------------------------------------------------------
`default_nettype none

module ocp_mul (
  input  wire                                 clk_i,
  input  wire                                 en_i,
  input  ocp_pkg::dir_t                       a_i,
  input  ocp_pkg::dir_t                       b_i,
  output logic signed [ocp_pkg::PROD_W-1:0]   p_o
);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= ocp_pkg::PROD_W'(a_i) * ocp_pkg::PROD_W'(b_i);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/orbit_camera_position_core.sv =====
// ----------------------------------------------------------------------------
// orbit_camera_position_core
// Orbit camera: updates radius or angles per command, then returns the
// Cartesian position and view direction from one shared CORDIC and one
// shared multiplier under a small sequencer.
// Result path: the command update, two CORDIC passes of one micro-rotation per
// cycle (longitude, then latitude) and five products through the multiplier.
// A new word is taken only while idle; in_stall_o is high
// from accept until the result has moved into the output register.
// Reset: latitude and longitude 0, radius 5.0, registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module orbit_camera_position_core #(
  parameter int CORDIC_STEPS = ocp_pkg::CORDIC_STEPS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // configuration
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire  [2:0]         cfg_index_i,
  input  wire  [23:0]        cfg_data_i,
  // command words
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [1:0]         command_i,
  input  wire  signed [24:0] step_distance_i,
  input  wire  signed [15:0] delta_longitude_i,
  input  wire  signed [15:0] delta_latitude_i,
  // result words
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [24:0] pos_x_o,
  output logic signed [24:0] pos_y_o,
  output logic signed [24:0] pos_z_o,
  output logic signed [15:0] view_x_o,
  output logic signed [15:0] view_y_o,
  output logic signed [15:0] view_z_o
);

  localparam int PW = ocp_pkg::PROD_W;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_UPD      = 12'b000000000010,
    S_LON_GO   = 12'b000000000100,
    S_LON_WAIT = 12'b000000001000,
    S_LAT_GO   = 12'b000000010000,
    S_LAT_WAIT = 12'b000000100000,
    S_MX       = 12'b000001000000,
    S_MZ       = 12'b000010000000,
    S_MPX      = 12'b000100000000,
    S_MPY      = 12'b001000000000,
    S_MPZ      = 12'b010000000000,
    S_OUT      = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [23:0] min_q, max_q, fx_q, fy_q, fz_q;
  // orbit state
  logic signed [15:0] lat_q;
  logic [16:0]        lon_q;
  logic [23:0]        radius_q;
  // latched command word
  ocp_pkg::cmd_e      cmd_q;
  logic signed [24:0] step_q;
  logic signed [15:0] dlon_q, dlat_q;
  // intermediate results
  ocp_pkg::dir_t      clon_q, slon_q, clat_q, slat_q, dx_q, dz_q;
  logic signed [24:0] px_q, py_q;

  ocp_pkg::cordic_res_t       cres;
  ocp_pkg::ang_t              cang;
  logic                       cstart;
  ocp_pkg::dir_t              ma, mb;
  logic                       men;
  logic signed [PW-1:0]       prod;
  ocp_pkg::dir_t              rad_op;

  logic signed [26:0] r_sum;
  logic signed [17:0] lat_sum;
  logic signed [18:0] lon_sum;
  logic               out_free;

  function automatic ocp_pkg::dir_t dir_round(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] rnd;
    rnd = p + (66'sd1 <<< 29);
    return ocp_pkg::DIR_W'(rnd >>> 30);
  endfunction

  function automatic logic signed [24:0] pos_calc(input logic signed [PW-1:0] p,
                                                  input logic [23:0] foc);
    logic signed [PW-1:0] rnd;
    logic signed [36:0]   s;
    logic signed [24:0]   r;
    rnd = p + (66'sd1 <<< 29);
    s   = 37'(rnd >>> 30) + 37'(signed'(foc));
    if (s > 37'(ocp_pkg::POS_MAX)) begin
      r = 25'(ocp_pkg::POS_MAX);
    end else if (s < 37'(ocp_pkg::POS_MIN)) begin
      r = 25'(ocp_pkg::POS_MIN);
    end else begin
      r = 25'(s);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] view_calc(input ocp_pkg::dir_t d);
    logic signed [17:0] v;
    logic signed [15:0] r;
    v = -(18'((d + 33'sd32768) >>> 16));
    if (v > 18'(ocp_pkg::VIEW_LIMIT)) begin
      r = 16'(ocp_pkg::VIEW_LIMIT);
    end else if (v < -18'(ocp_pkg::VIEW_LIMIT)) begin
      r = -16'(ocp_pkg::VIEW_LIMIT);
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  ocp_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cstart),
    .angle_i(cang),
    .res_o  (cres)
  );

  ocp_mul u_mul (
    .clk_i(clk_i),
    .en_i (men),
    .a_i  (ma),
    .b_i  (mb),
    .p_o  (prod)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_valid_o || !out_stall_i;
  assign rad_op      = ocp_pkg::DIR_W'({1'b0, radius_q});

  // state update arithmetic
  always_comb begin
    r_sum = (cmd_q == ocp_pkg::CMD_FWD) ?
            $signed({3'b000, radius_q}) - 27'(step_q) :
            $signed({3'b000, radius_q}) + 27'(step_q);
    lat_sum = 18'(lat_q) + 18'(dlat_q);
    lon_sum = $signed({2'b00, lon_q}) + 19'(dlon_q);
  end

  // CORDIC and multiplier operand selection
  always_comb begin
    cstart = (state_q == S_LON_GO) || (state_q == S_LAT_GO);
    cang   = (state_q == S_LAT_GO) ? ocp_pkg::ang_t'(lat_q) :
                                     ocp_pkg::ang_t'({1'b0, lon_q});
    men    = 1'b1;
    ma     = clon_q;
    mb     = clat_q;
    case (state_q)
      S_MX: begin
        ma = clon_q;
        mb = clat_q;
      end
      S_MZ: begin
        ma = slon_q;
        mb = clat_q;
      end
      S_MPX: begin
        ma = rad_op;
        mb = dx_q;
      end
      S_MPY: begin
        ma = rad_op;
        mb = slat_q;
      end
      S_MPZ: begin
        ma = rad_op;
        mb = dz_q;
      end
      default: begin
        men = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_UPD;
      S_UPD:      state_d = S_LON_GO;
      S_LON_GO:   state_d = S_LON_WAIT;
      S_LON_WAIT: if (cres.done) state_d = S_LAT_GO;
      S_LAT_GO:   state_d = S_LAT_WAIT;
      S_LAT_WAIT: if (cres.done) state_d = S_MX;
      S_MX:       state_d = S_MZ;
      S_MZ:       state_d = S_MPX;
      S_MPX:      state_d = S_MPY;
      S_MPY:      state_d = S_MPZ;
      S_MPZ:      state_d = S_OUT;
      S_OUT:      if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      min_q       <= ocp_pkg::MIN_RADIUS_RST;
      max_q       <= ocp_pkg::MAX_RADIUS_RST;
      fx_q        <= '0;
      fy_q        <= '0;
      fz_q        <= '0;
      lat_q       <= '0;
      lon_q       <= '0;
      radius_q    <= ocp_pkg::RADIUS_RST;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          ocp_pkg::CFG_MIN_RADIUS: min_q <= cfg_data_i;
          ocp_pkg::CFG_MAX_RADIUS: max_q <= cfg_data_i;
          ocp_pkg::CFG_FOCUS_X:    fx_q  <= cfg_data_i;
          ocp_pkg::CFG_FOCUS_Y:    fy_q  <= cfg_data_i;
          ocp_pkg::CFG_FOCUS_Z:    fz_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == S_UPD) begin
        if (cmd_q == ocp_pkg::CMD_FWD || cmd_q == ocp_pkg::CMD_BACK) begin
          // crossed bounds: a sum below min gives min, any other sum gives max
          if (r_sum < $signed({3'b000, min_q})) begin
            radius_q <= min_q;
          end else if (r_sum > $signed({3'b000, max_q})) begin
            radius_q <= max_q;
          end else begin
            radius_q <= r_sum[23:0];
          end
        end else if (cmd_q == ocp_pkg::CMD_ORIENT) begin
          if (lat_sum > 18'(ocp_pkg::LAT_LIMIT)) begin
            lat_q <= 16'(ocp_pkg::LAT_LIMIT);
          end else if (lat_sum < -18'(ocp_pkg::LAT_LIMIT)) begin
            lat_q <= -16'(ocp_pkg::LAT_LIMIT);
          end else begin
            lat_q <= 16'(lat_sum);
          end
          if (lon_sum < 19'sd0) begin
            lon_q <= 17'(lon_sum + 19'(ocp_pkg::FULL_TURN));
          end else if (lon_sum >= 19'(ocp_pkg::FULL_TURN)) begin
            lon_q <= 17'(lon_sum - 19'(ocp_pkg::FULL_TURN));
          end else begin
            lon_q <= 17'(lon_sum);
          end
        end
      end

      if (state_q == S_OUT && out_free) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q  <= ocp_pkg::cmd_e'(command_i);
      step_q <= step_distance_i;
      dlon_q <= delta_longitude_i;
      dlat_q <= delta_latitude_i;
    end
    if (state_q == S_LON_WAIT && cres.done) begin
      clon_q <= cres.cos_v;
      slon_q <= cres.sin_v;
    end
    if (state_q == S_LAT_WAIT && cres.done) begin
      clat_q <= cres.cos_v;
      slat_q <= cres.sin_v;
    end
    // each capture takes the product issued one state earlier
    if (state_q == S_MZ)  dx_q <= dir_round(prod);
    if (state_q == S_MPX) dz_q <= dir_round(prod);
    if (state_q == S_MPY) px_q <= pos_calc(prod, fx_q);
    if (state_q == S_MPZ) py_q <= pos_calc(prod, fy_q);
    if (state_q == S_OUT && out_free) begin
      pos_x_o  <= px_q;
      pos_y_o  <= py_q;
      pos_z_o  <= pos_calc(prod, fz_q);
      view_x_o <= view_calc(dx_q);
      view_y_o <= view_calc(slat_q);
      view_z_o <= view_calc(dz_q);
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/orbit_camera_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// orbit_camera_checker
// Watches the register, command and result channels of the orbit camera,
// predicts each position and view word from its own copy of the orbit state
// and compares every result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module orbit_camera_checker
  import ocp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         command_i,
  input  logic signed [24:0] step_distance_i,
  input  logic signed [15:0] delta_longitude_i,
  input  logic signed [15:0] delta_latitude_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [24:0] pos_x_i,
  input  logic signed [24:0] pos_y_i,
  input  logic signed [24:0] pos_z_i,
  input  logic signed [15:0] view_x_i,
  input  logic signed [15:0] view_y_i,
  input  logic signed [15:0] view_z_i,
  output int                 fail_count,
  output int                 poses_owed
);

  typedef struct {
    logic signed [24:0] pos [3];
    logic signed [15:0] view [3];
  } pose_t;

  localparam int ATAN_LEN = 24;

  // atan(2^-i) in 1/65536 degree
  longint atan_step [0:ATAN_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  pose_t              pose_queue [$];
  logic [23:0]        min_radius;
  logic [23:0]        max_radius;
  logic signed [23:0] focus [3];
  logic signed [15:0] lat_angle;
  logic [16:0]        lon_angle;
  logic [23:0]        orbit_radius;

  initial begin
    fail_count = 0;
    poses_owed = 0;
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // rotation-mode CORDIC, angle in 1/256 degree, results in Q1.30
  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     flip;
    a    = ang;
    x    = CORDIC_GAIN;
    y    = 0;
    flip = 1'b0;
    while (a >= HALF_TURN) a -= FULL_TURN;
    while (a < -HALF_TURN) a += FULL_TURN;
    // fold into -90..90 and negate the vector afterwards
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN;
      flip = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN;
      flip = 1'b1;
    end
    z = a * 256;
    for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_step[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_step[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // apply one command to the orbit state and return the resulting pose
  function automatic pose_t camera_pose(cmd_e cmd, logic signed [24:0] step,
                                        logic signed [15:0] dlon,
                                        logic signed [15:0] dlat);
    longint r;
    longint lo;
    longint hi;
    longint lat;
    longint lon;
    longint clon;
    longint slon;
    longint clat;
    longint slat;
    longint dir [3];
    pose_t  res;
    case (cmd)
      CMD_FWD, CMD_BACK: begin
        r  = {40'd0, orbit_radius};
        lo = {40'd0, min_radius};
        hi = {40'd0, max_radius};
        r  = (cmd == CMD_FWD) ? r - step : r + step;
        // crossed bounds: a sum below the minimum gives it, any other the maximum
        if (r < lo) r = lo;
        else if (r > hi) r = hi;
        orbit_radius = r[23:0];
      end
      CMD_ORIENT: begin
        lat = lat_angle;
        lat = clip(lat + dlat, -LAT_LIMIT, LAT_LIMIT);
        lon = {47'd0, lon_angle};
        lon = (lon + dlon) % FULL_TURN;
        if (lon < 0) lon += FULL_TURN;
        lat_angle = lat[15:0];
        lon_angle = lon[16:0];
      end
      default: ;
    endcase
    lon = {47'd0, lon_angle};
    lat = lat_angle;
    sin_cos(lon, clon, slon);
    sin_cos(lat, clat, slat);
    dir[0] = round_shift(clon * clat, 30);
    dir[1] = slat;
    dir[2] = round_shift(slon * clat, 30);
    r = {40'd0, orbit_radius};
    for (int k = 0; k < 3; k++) begin
      res.pos[k]  = 25'(clip(round_shift(r * dir[k], 30) + focus[k],
                             POS_MIN, POS_MAX));
      res.view[k] = 16'(clip(-round_shift(dir[k], 16), -VIEW_LIMIT, VIEW_LIMIT));
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pose_t got;
    pose_t due;
    bit    bad;
    if (!rst_ni) begin
      min_radius   = MIN_RADIUS_RST;
      max_radius   = MAX_RADIUS_RST;
      focus[0]     = '0;
      focus[1]     = '0;
      focus[2]     = '0;
      lat_angle    = '0;
      lon_angle    = '0;
      orbit_radius = RADIUS_RST;
      pose_queue.delete();
      poses_owed   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_RADIUS: min_radius = cfg_data_i;
          CFG_MAX_RADIUS: max_radius = cfg_data_i;
          CFG_FOCUS_X:    focus[0]   = cfg_data_i;
          CFG_FOCUS_Y:    focus[1]   = cfg_data_i;
          CFG_FOCUS_Z:    focus[2]   = cfg_data_i;
          default: ;  // drop writes to unused indexes
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        pose_queue.push_back(camera_pose(cmd_e'(command_i), step_distance_i,
                                         delta_longitude_i, delta_latitude_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got.pos[0]  = pos_x_i;
        got.pos[1]  = pos_y_i;
        got.pos[2]  = pos_z_i;
        got.view[0] = view_x_i;
        got.view[1] = view_y_i;
        got.view[2] = view_z_i;
        if (pose_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result word: pos %0d %0d %0d view %0d %0d %0d",
                     $realtime, got.pos[0], got.pos[1], got.pos[2],
                     got.view[0], got.view[1], got.view[2]);
        end else begin
          due = pose_queue.pop_front();
          bad = 1'b0;
          for (int k = 0; k < 3; k++)
            if (got.pos[k] !== due.pos[k] || got.view[k] !== due.view[k]) bad = 1'b1;
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: pose mismatch: got pos %0d %0d %0d view %0d %0d %0d",
                       $realtime, got.pos[0], got.pos[1], got.pos[2],
                       got.view[0], got.view[1], got.view[2]);
              $display("%0t:               want pos %0d %0d %0d view %0d %0d %0d",
                       $realtime, due.pos[0], due.pos[1], due.pos[2],
                       due.view[0], due.view[1], due.view[2]);
            end
          end
        end
      end
      poses_owed = pose_queue.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the orbit camera with directed and random command words under
// several register settings, with random gaps and result stalls, and
// reports the verdict of the attached checker.
// ----------------------------------------------------------------------------

module tb;
  import ocp_pkg::*;

  localparam int PHASES         = 8;
  localparam int WORDS_PER_PHASE = 236;
  localparam int DRAIN_CYCLES   = 2 * CORDIC_STEPS_DEF + 32;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [23:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         command_i = '0;
  logic signed [24:0] step_distance_i = '0;
  logic signed [15:0] delta_longitude_i = '0;
  logic signed [15:0] delta_latitude_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [24:0] pos_x_o;
  logic signed [24:0] pos_y_o;
  logic signed [24:0] pos_z_o;
  logic signed [15:0] view_x_o;
  logic signed [15:0] view_y_o;
  logic signed [15:0] view_z_o;

  int fail_count;
  int poses_owed;
  bit calm = 1'b0;
  int stall_left = 0;

  always #1 clk_i = ~clk_i;

  orbit_camera_position_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .step_distance_i   (step_distance_i),
    .delta_longitude_i (delta_longitude_i),
    .delta_latitude_i  (delta_latitude_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pos_x_o           (pos_x_o),
    .pos_y_o           (pos_y_o),
    .pos_z_o           (pos_z_o),
    .view_x_o          (view_x_o),
    .view_y_o          (view_y_o),
    .view_z_o          (view_z_o)
  );

  orbit_camera_checker camera_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .command_i         (command_i),
    .step_distance_i   (step_distance_i),
    .delta_longitude_i (delta_longitude_i),
    .delta_latitude_i  (delta_latitude_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pos_x_i           (pos_x_o),
    .pos_y_i           (pos_y_o),
    .pos_z_i           (pos_z_o),
    .view_x_i          (view_x_o),
    .view_y_i          (view_y_o),
    .view_z_i          (view_z_o),
    .fail_count        (fail_count),
    .poses_owed        (poses_owed)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result-side back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall_i = !calm && ($urandom_range(0, 7) == 0);
      stall_left  = out_stall_i ? pick_gap() : 0;
    end
  end

  // entered and left at a falling edge; valid stays high for the next word
  task automatic send_word(cmd_e cmd, logic signed [24:0] step,
                           logic signed [15:0] dlon, logic signed [15:0] dlat);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    command_i         = cmd;
    step_distance_i   = step;
    delta_longitude_i = dlon;
    delta_latitude_i  = dlat;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // leaves valid high so back-to-back writes need no drop in between
  task automatic cfg_write(logic [2:0] idx, logic [23:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // hold off until every pose has come back
  task automatic settle();
    in_valid_i = 1'b0;
    while (poses_owed != 0) @(negedge clk_i);
  endtask

  task automatic apply_setting(int ph);
    int lo;
    case (ph)
      0: begin
        cfg_write(CFG_MIN_RADIUS, MIN_RADIUS_RST);
        cfg_write(CFG_MAX_RADIUS, MAX_RADIUS_RST);
        cfg_write(CFG_FOCUS_X, '0);
        cfg_write(CFG_FOCUS_Y, '0);
        cfg_write(CFG_FOCUS_Z, '0);
      end
      1: begin
        // crossed bounds: sums below the minimum give it, all others the maximum
        cfg_write(CFG_MIN_RADIUS, 24'($urandom_range(400000, 800000)));
        cfg_write(CFG_MAX_RADIUS, 24'($urandom_range(65536, 300000)));
      end
      2: begin
        lo = $urandom_range(1, 2000000);
        cfg_write(CFG_MIN_RADIUS, 24'(lo));
        cfg_write(CFG_MAX_RADIUS, 24'(lo));
      end
      3: begin
        cfg_write(CFG_MIN_RADIUS, '0);
        cfg_write(CFG_MAX_RADIUS, '1);
        cfg_write(CFG_FOCUS_X, 24'($urandom));
        cfg_write(CFG_FOCUS_Y, 24'($urandom));
        cfg_write(CFG_FOCUS_Z, 24'($urandom));
      end
      4: begin
        for (int k = CFG_FOCUS_Z + 1; k < (1 << $bits(cfg_index_i)); k++)
          cfg_write(3'(k), 24'($urandom));
        lo = $urandom_range(0, 200000);
        cfg_write(CFG_MIN_RADIUS, 24'(lo));
        cfg_write(CFG_MAX_RADIUS, 24'(lo + $urandom_range(0, 1000000)));
      end
      5: begin
        cfg_write(CFG_MIN_RADIUS, 24'($urandom_range(0, 1000)));
        cfg_write(CFG_MAX_RADIUS, '1);
        cfg_write(CFG_FOCUS_X, 24'h800000);
        cfg_write(CFG_FOCUS_Y, 24'h7FFFFF);
        cfg_write(CFG_FOCUS_Z, 24'h800000);
      end
      default: begin
        cfg_write(CFG_MIN_RADIUS, 24'($urandom));
        cfg_write(CFG_MAX_RADIUS, 24'($urandom));
        cfg_write(CFG_FOCUS_X, 24'($urandom));
        cfg_write(CFG_FOCUS_Y, 24'($urandom));
        cfg_write(CFG_FOCUS_Z, 24'($urandom));
      end
    endcase
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic signed [24:0] rand_step();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 25'($urandom_range(0, 524288) - 262144);
    if (r < 9) return 25'($urandom_range(0, 8388608) - 4194304);
    return 25'($urandom);
  endfunction

  function automatic logic signed [15:0] rand_delta();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(0, 2048) - 1024);
    if (r < 9) return 16'($urandom_range(0, 46080) - 23040);
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    int   r;
    cmd_e cmd;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // defaults: ignored fields, radius clamps, latitude clamps, longitude wrap
    send_word(CMD_SIDE, 12345, -7, 9);
    send_word(CMD_FWD, 0, 0, 0);
    send_word(CMD_FWD, 65536, 0, 0);
    send_word(CMD_BACK, 131072, 32767, -32768);
    send_word(CMD_FWD, 16777215, 0, 0);
    send_word(CMD_BACK, 16777215, 0, 0);
    send_word(CMD_FWD, -16777216, 0, 0);
    send_word(CMD_BACK, -16777216, 0, 0);
    send_word(CMD_ORIENT, 16777215, QUARTER_TURN, 32767);
    send_word(CMD_ORIENT, -16777216, QUARTER_TURN, -32768);
    send_word(CMD_ORIENT, 0, 32767, LAT_LIMIT);
    send_word(CMD_ORIENT, 0, 32767, 0);
    send_word(CMD_ORIENT, 0, -32768, 1);
    send_word(CMD_ORIENT, 0, -32768, -1);
    send_word(CMD_ORIENT, 0, -32768, 0);
    settle();

    // open bounds and extreme focus: zero radius, then position saturation
    cfg_write(CFG_MIN_RADIUS, '0);
    cfg_write(CFG_MAX_RADIUS, '1);
    cfg_write(CFG_FOCUS_X, 24'h7FFFFF);
    cfg_write(CFG_FOCUS_Y, 24'h800000);
    cfg_write(CFG_FOCUS_Z, 24'h7FFFFF);
    cfg_valid_i = 1'b0;
    send_word(CMD_FWD, 16777215, 0, 0);
    send_word(CMD_SIDE, -1, -1, -1);
    send_word(CMD_BACK, 16777215, 0, 0);
    send_word(CMD_ORIENT, 0, 4096, -4096);
    send_word(CMD_ORIENT, 0, 0, -32768);
    send_word(CMD_FWD, -1, 0, 0);
    send_word(CMD_ORIENT, 0, 0, 32767);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_setting(ph);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 30) cmd = CMD_FWD;
        else if (r < 60) cmd = CMD_BACK;
        else if (r < 90) cmd = CMD_ORIENT;
        else cmd = CMD_SIDE;
        send_word(cmd, rand_step(), rand_delta(), rand_delta());
      end
      settle();
    end

    calm = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && poses_owed == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ocp_pkg.sv
rtl/ocp_cordic.sv
rtl/ocp_mul.sv
rtl/orbit_camera_position_core.sv
tb/sv/orbit_camera_checker.sv
tb/sv/tb.sv
